@@ sv/shs_pkg.sv @@
`default_nettype none
package shs_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int FILL_W = 6;
	localparam logic [FILL_W-1:0] LEN_POS = 6'd56;
	localparam logic [FILL_W-1:0] LAST_FILL = 6'd63;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_INIT,
		ST_COMP,
		ST_FOLD,
		ST_OUT
	} shs_state_t;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} shs_src_t;

	typedef struct packed {
		logic     append;
		shs_src_t src;
		logic     count_len;
		logic     load_v;
		logic     round_en;
		logic     fold;
		logic     out_step;
		logic     restart;
	} shs_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              round_last;
		logic              word_last;
	} shs_status_t;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

	function automatic logic [31:0] k_const(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

@@ sv/shs_in_if.sv @@
`default_nettype none
interface shs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface
`default_nettype wire

@@ sv/shs_out_if.sv @@
`default_nettype none
interface shs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface
`default_nettype wire

@@ sv/shs_ctrl.sv @@
`default_nettype none
module shs_ctrl
	import shs_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_byte_present,
	input  wire         in_end_of_message,
	output logic        in_ready,
	output logic        out_valid,
	input  wire         out_ready,
	input  shs_status_t status,
	output shs_cmd_t    cmd
);

	shs_state_t state_q, state_d;
	// where to go once the current block has been folded into the hash
	shs_state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		cmd       = '0;
		cmd.src   = SRC_DATA;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_byte_present) begin
						cmd.append    = 1'b1;
						cmd.count_len = 1'b1;
					end
					if (in_byte_present && status.fill == LAST_FILL) begin
						state_d = ST_INIT;
						ret_d   = in_end_of_message ? ST_PAD_MARK : ST_IDLE;
					end else if (in_end_of_message) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				cmd.append = 1'b1;
				cmd.src    = SRC_MARK;
				if (status.fill == LAST_FILL) begin
					state_d = ST_INIT;
					ret_d   = ST_PAD_ZERO;
				end else begin
					state_d = ST_PAD_ZERO;
				end
			end
			ST_PAD_ZERO: begin
				if (status.fill == LEN_POS) begin
					state_d = ST_PAD_LEN;
				end else begin
					cmd.append = 1'b1;
					cmd.src    = SRC_ZERO;
					if (status.fill == LAST_FILL) begin
						state_d = ST_INIT;
						ret_d   = ST_PAD_ZERO;
					end
				end
			end
			ST_PAD_LEN: begin
				cmd.append = 1'b1;
				cmd.src    = SRC_LEN;
				if (status.fill == LAST_FILL) begin
					state_d = ST_INIT;
					ret_d   = ST_OUT;
				end
			end
			ST_INIT: begin
				cmd.load_v = 1'b1;
				state_d    = ST_COMP;
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
				if (status.round_last) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ret_q;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_step = 1'b1;
					if (status.word_last) begin
						cmd.restart = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/shs_datapath.sv @@
`default_nettype none
module shs_datapath
	import shs_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  shs_cmd_t     cmd,
	input  wire  [7:0]   in_byte,
	output shs_status_t  status,
	output logic [31:0]  digest_word,
	output logic [2:0]   word_index,
	output logic         last_word
);

	localparam int MSG_W = BLOCK_BYTES * 8;

	// block buffer as a byte shift line; during rounds it doubles as the
	// 16-word schedule window, oldest word at the top
	logic [MSG_W-1:0]  msg_q;
	logic [FILL_W-1:0] fill_q;
	logic [63:0]       bitlen_q;
	logic [31:0]       h_q [8];
	logic [31:0]       v_q [8];
	logic [5:0]        round_q;
	logic [2:0]        widx_q;

	logic [7:0]  app_byte;
	logic [5:0]  len_shift;
	logic [63:0] len_shr;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2;

	assign len_shift = {~fill_q[2:0], 3'b000};
	assign len_shr   = bitlen_q >> len_shift;

	always_comb begin
		case (cmd.src)
			SRC_DATA: app_byte = in_byte;
			SRC_MARK: app_byte = PAD_MARK;
			SRC_ZERO: app_byte = 8'h00;
			SRC_LEN:  app_byte = len_shr[7:0];
			default:  app_byte = 8'h00;
		endcase
	end

	assign w0    = msg_q[MSG_W-1      -: 32];
	assign w1    = msg_q[MSG_W-1-32   -: 32];
	assign w9    = msg_q[MSG_W-1-32*9 -: 32];
	assign w14   = msg_q[MSG_W-1-32*14 -: 32];
	assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

	assign t1 = v_q[7] + bsig1(v_q[4]) + ch(v_q[4], v_q[5], v_q[6]) + k_const(round_q) + w0;
	assign t2 = bsig0(v_q[0]) + maj(v_q[0], v_q[1], v_q[2]);

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			msg_q <= {msg_q[MSG_W-9:0], app_byte};
		end else if (cmd.round_en) begin
			msg_q <= {msg_q[MSG_W-33:0], w_new};
		end
		if (cmd.load_v) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (cmd.round_en) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			bitlen_q <= '0;
			round_q  <= '0;
			widx_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			if (cmd.restart) begin
				fill_q   <= '0;
				bitlen_q <= '0;
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= H_INIT[i];
				end
			end else begin
				if (cmd.append) begin
					fill_q <= fill_q + 1'b1;
				end
				if (cmd.count_len) begin
					bitlen_q <= bitlen_q + 64'd8;
				end
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
				end
			end
			if (cmd.round_en) begin
				round_q <= round_q + 1'b1;
			end
			if (cmd.out_step) begin
				widx_q <= widx_q + 1'b1;
			end
		end
	end

	assign status.fill       = fill_q;
	assign status.round_last = (round_q == 6'd63);
	assign status.word_last  = (widx_q == 3'd7);

	assign digest_word = h_q[widx_q];
	assign word_index  = widx_q;
	assign last_word   = (widx_q == 3'd7);

endmodule
`default_nettype wire

@@ sv/sha256_stream_hasher_core.sv @@
`default_nettype none
// SHA-256 hasher, one message byte per input transaction. A transaction with
// byte_present set appends its byte; end_of_message then pads the message and
// returns eight digest words, H0 first, before the next message starts from
// the initial hash. A byte that does not complete a 64-byte block leaves the
// core ready for the next one. A completed block is loaded into the working
// variables, run through 64 rounds and folded into the hash, and input is
// held off meanwhile. Finishing appends the padding bytes (up to 72) one at a
// time, with an idle step ahead of the length field, plus one or two block
// compressions, then the eight digest words are offered one per cycle while
// the sink accepts; no new input is taken until the last word is accepted.
module sha256_stream_hasher_core
	import shs_pkg::*;
(
	input wire         clk,
	input wire         arst_n,
	shs_in_if.sink     in_ch,
	shs_out_if.source  out_ch
);

	shs_cmd_t    cmd;
	shs_status_t status;

	shs_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_ch.valid),
		.in_byte_present   (in_ch.byte_present),
		.in_end_of_message (in_ch.end_of_message),
		.in_ready          (in_ch.ready),
		.out_valid         (out_ch.valid),
		.out_ready         (out_ch.ready),
		.status            (status),
		.cmd               (cmd)
	);

	shs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_byte     (in_ch.data_byte),
		.status      (status),
		.digest_word (out_ch.digest_word),
		.word_index  (out_ch.word_index),
		.last_word   (out_ch.last_word)
	);

endmodule
`default_nettype wire

@@ tb/sha256_stream_hasher_core_test.sv @@
`default_nettype none
module sha256_stream_hasher_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 200;
	localparam int ITEM_TARGET = 310;
	localparam int LEN_FIELD_AT = 56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	// message lengths around the padding and block boundaries
	localparam int BOUNDARY_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	typedef struct packed {
		logic [7:0]   data;
		logic         present;
		logic         eom;
		logic         given;
		logic [255:0] digest;
	} directed_row_t;

	typedef struct packed {
		logic         given;
		logic [255:0] digest;
	} quoted_digest_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	// given digests are typed in only for well-known messages
	localparam directed_row_t DIRECTED [12] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
		'{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
		'{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
		'{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 256'h0},
		'{8'h80, 1'b1, 1'b1, 1'b0, 256'h0},
		'{8'h55, 1'b0, 1'b0, 1'b0, 256'h0},
		'{8'haa, 1'b1, 1'b1, 1'b0, 256'h0},
		'{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
	};

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycle_count = 0;
	int items_sent = 0;
	int mismatches = 0;
	logic calm;

	shs_in_if in_ch();
	shs_out_if out_ch();

	sha256_stream_hasher_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #10 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// no idling on either side through a stretch of the random traffic
	assign calm = (items_sent >= 100) && (items_sent < 180);

	// hash chain, block buffer, fill and bit length of the message in flight
	logic [31:0] chain_h [8];
	logic [7:0]  blk_bytes [64];
	logic [5:0]  blk_fill;
	logic [63:0] msg_bits;

	digest_word_t   digest_words_due [$];
	quoted_digest_t quoted_digests [$];

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_restart();
		int i;
		for (i = 0; i < 8; i++)
			chain_h[i] = SHA_IV[i];
		blk_fill = '0;
		msg_bits = '0;
	endfunction

	function automatic void sha_compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (i = 0; i < 8; i++)
			v[i] = chain_h[i];
		for (i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			chain_h[i] = chain_h[i] + v[i];
	endfunction

	function automatic void sha_take_item(input logic [7:0] data, input logic present,
			input logic eom, input quoted_digest_t quoted);
		digest_word_t dw;
		int pos;
		int i;
		if (present) begin
			blk_bytes[blk_fill] = data;
			msg_bits = msg_bits + 64'd8;
			blk_fill = blk_fill + 6'd1;
			if (blk_fill == 6'd0)
				sha_compress();
		end
		if (eom) begin
			pos = int'(blk_fill);
			blk_bytes[pos] = PAD_BYTE;
			pos++;
			// no room for the length field: pad out and spill into one more block
			if (pos > LEN_FIELD_AT) begin
				while (pos < 64) begin
					blk_bytes[pos] = 8'h00;
					pos++;
				end
				sha_compress();
				pos = 0;
			end
			while (pos < LEN_FIELD_AT) begin
				blk_bytes[pos] = 8'h00;
				pos++;
			end
			for (i = 0; i < 8; i++)
				blk_bytes[LEN_FIELD_AT + i] = msg_bits[63 - 8*i -: 8];
			sha_compress();
			for (i = 0; i < 8; i++) begin
				dw.word = quoted.given ? quoted.digest[255 - 32*i -: 32] : chain_h[i];
				dw.idx = 3'(i);
				dw.last = (i == 7);
				digest_words_due.push_back(dw);
			end
			sha_restart();
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : watch
		digest_word_t due;
		quoted_digest_t quoted;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (digest_words_due.size() == 0) begin
				report_mismatch($sformatf("unexpected digest word %h index %0d",
					out_ch.digest_word, out_ch.word_index));
			end else begin
				due = digest_words_due.pop_front();
				if (out_ch.digest_word !== due.word)
					report_mismatch($sformatf("word %0d: digest_word %h, want %h",
						due.idx, out_ch.digest_word, due.word));
				if (out_ch.word_index !== due.idx)
					report_mismatch($sformatf("word_index %0d, want %0d",
						out_ch.word_index, due.idx));
				if (out_ch.last_word !== due.last)
					report_mismatch($sformatf("word %0d: last_word %b, want %b",
						due.idx, out_ch.last_word, due.last));
			end
		end
		if (arst_n && in_ch.valid && in_ch.ready) begin
			quoted = '0;
			if (in_ch.end_of_message)
				quoted = quoted_digests.pop_front();
			sha_take_item(in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message, quoted);
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = calm || ($urandom_range(99) >= 10);
		end
	end

	task automatic send_item(input logic [7:0] data, input logic present, input logic eom,
			input logic given, input logic [255:0] digest);
		quoted_digest_t quoted;
		while (!calm && $urandom_range(99) < 10) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		if (eom) begin
			quoted.given = given;
			quoted.digest = digest;
			quoted_digests.push_back(quoted);
		end
		in_ch.data_byte = data;
		in_ch.byte_present = present;
		in_ch.end_of_message = eom;
		in_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (digest_words_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_message();
		int len;
		int k;
		logic tail;
		case ($urandom_range(9))
			0, 1, 2, 3: len = $urandom_range(12);
			4, 5, 6, 7: len = BOUNDARY_LENS[$urandom_range(9)];
			default: len = $urandom_range(140);
		endcase
		// keep the last message from running far past the item budget
		if (len > ITEM_TARGET - items_sent)
			len = ITEM_TARGET - items_sent;
		// last byte may ride on the end-of-message transaction
		tail = (len > 0) && ($urandom_range(1) == 1);
		for (k = 0; k < len - int'(tail); k++) begin
			if ($urandom_range(19) == 0)
				send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
			send_item(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
		end
		send_item(8'($urandom), tail, 1'b1, 1'b0, '0);
	endtask

	initial begin
		int r;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.byte_present = 1'b0;
		in_ch.end_of_message = 1'b0;
		sha_restart();
		for (r = 0; r < 64; r++)
			blk_bytes[r] = 8'h00;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < 12; r++)
			send_item(DIRECTED[r].data, DIRECTED[r].present, DIRECTED[r].eom,
				DIRECTED[r].given, DIRECTED[r].digest);
		wait_drained();

		while (items_sent < ITEM_TARGET) begin
			send_message();
			if ($urandom_range(4) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && digest_words_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
